### hw/rtl/slst_pkg.sv
// ----------------------------------------------------------------------------
// slst_pkg
// Shared codes and types of the sorted list store.
// ----------------------------------------------------------------------------
`default_nettype none

package slst_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DISPLAY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } state_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [DATA_W-1:0]  value;
        logic                      del_found;
    } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/slst_in_if.sv
// ----------------------------------------------------------------------------
// slst_in_if
// Request channel: opcode and value with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface slst_in_if
    import slst_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

### hw/rtl/slst_out_if.sv
// ----------------------------------------------------------------------------
// slst_out_if
// Response channel: status, item and last with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface slst_out_if
    import slst_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item;
    logic                     last;

    modport source (output valid, output status, output item, output last, input ready);
    modport sink   (input valid, input status, input item, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/slst_cell.sv
// ----------------------------------------------------------------------------
// slst_cell
// One storage slot of the sorted chain: compares, holds or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module slst_cell
    import slst_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_ctl_t                ctl,
    input  wire logic                     left_keep,
    input  wire logic signed [DATA_W-1:0] left_val,
    input  wire logic                     left_occ,
    input  wire logic signed [DATA_W-1:0] right_val,
    input  wire logic                     right_occ,
    input  wire logic signed [DATA_W-1:0] head_val,
    output logic                          keep,
    output logic                          match,
    output logic signed [DATA_W-1:0]      val,
    output logic                          occ
);

    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                     occ_reg, occ_next;
    logic                     less;

    assign keep  = occ_reg && (val_reg <= ctl.value);
    assign less  = occ_reg && (val_reg < ctl.value);
    assign match = occ_reg && (val_reg == ctl.value);
    assign val   = val_reg;
    assign occ   = occ_reg;

    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        unique case (ctl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        val_next = ctl.value;
                        occ_next = 1'b1;
                    end
                    else
                    begin
                        val_next = left_val;
                        occ_next = left_occ;
                    end
                end
            end
            CMD_DELETE:
            begin
                if (ctl.del_found && occ_reg && !less)
                begin
                    val_next = right_val;
                    occ_next = right_occ;
                end
            end
            CMD_ROTATE:
            begin
                if (occ_reg)
                begin
                    val_next = right_occ ? right_val : head_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

### hw/rtl/slst_ctrl.sv
// ----------------------------------------------------------------------------
// slst_ctrl
// Sequencer: decodes requests, drives the chain, owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slst_ctrl
    import slst_pkg::*;
#(
    parameter int unsigned CAPACITY = 32,
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    slst_in_if.sink                       in_ch,
    slst_out_if.source                    out_ch,
    input  wire logic                     found,
    input  wire logic signed [DATA_W-1:0] head_val,
    output cell_ctl_t                     ctl,
    output logic [CW-1:0]                 count
);

    state_t state_reg, state_next;

    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            rem_reg, rem_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] item_reg, item_next;
    logic                     last_reg, last_next;
    logic                     out_free;
    logic                     fire;
    logic                     load;
    logic                     full;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign fire        = in_ch.valid && in_ch.ready;
    assign full        = (count_reg == CW'(CAPACITY));

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.item   = item_reg;
    assign out_ch.last   = last_reg;
    assign count         = count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire && in_ch.opcode == OP_DISPLAY && count_reg != '0)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (out_free && rem_reg == CW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.cmd       = CMD_HOLD;
        ctl.value     = in_ch.value;
        ctl.del_found = found;
        count_next    = count_reg;
        rem_next      = rem_reg;
        load          = 1'b0;
        status_next   = status_reg;
        item_next     = item_reg;
        last_next     = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    item_next = '0;
                    last_next = 1'b1;
                    if (in_ch.opcode == OP_INSERT)
                    begin
                        load = 1'b1;
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            ctl.cmd     = CMD_INSERT;
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    else if (in_ch.opcode == OP_DELETE)
                    begin
                        load = 1'b1;
                        if (found)
                        begin
                            status_next = ST_OK;
                            ctl.cmd     = CMD_DELETE;
                            count_next  = count_reg - CW'(1);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    else if (in_ch.opcode == OP_DISPLAY)
                    begin
                        if (count_reg == '0)
                        begin
                            load        = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rem_next = count_reg;
                        end
                    end
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    ctl.cmd     = CMD_ROTATE;
                    status_next = ST_OK;
                    item_next   = head_val;
                    last_next   = (rem_reg == CW'(1));
                    rem_next    = rem_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_disp_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DISP |-> rem_reg != '0)
        else $error("display running with nothing left");

    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_ch.opcode == OP_INSERT && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the store");

    a_disp_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DISP && out_free && rem_reg == CW'(1) |=> state_reg == S_IDLE && last_reg)
        else $error("display did not end on last");
`endif

endmodule

`default_nettype wire

### hw/rtl/sorted_list_store_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_store_unit
// Sorted store of up to CAPACITY signed words built as a chain of cells.
//
// in_ch carries opcode and value; out_ch carries status, item and last.
// Insert and delete are each one transaction in, one transaction out: every
// cell compares against the value in parallel and shifts right (insert) or
// left (delete) in the accept cycle, so the result is valid the next cycle.
// Display returns one transaction per stored value, one per cycle while
// out_ch.ready is high, by rotating the chain one place per output; after
// count rotations the chain is back in order. Display on an empty store
// returns one empty status. Insert, delete and empty display load the result
// in the accept cycle; a non-empty display loads its first result from
// S_DISP, entered on accept. Insert and delete run at one transaction per
// cycle while out_ch.ready is high; a non-empty display holds the block in
// S_DISP, and no request is taken until its last result is loaded.
// The result register holds while out_ch.ready is low, and in_ch.ready drops
// until it frees up, so a stalled receiver stalls the block.
// Reset (rst_n low) empties the store and clears any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_store_unit
    import slst_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    slst_in_if.sink    in_ch,
    slst_out_if.source out_ch
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    cell_ctl_t                ctl;
    logic [CW-1:0]            count;
    logic                     found;
    logic [CAPACITY-1:0]      keep_vec;
    logic [CAPACITY-1:0]      match_vec;
    logic [CAPACITY-1:0]      occ_vec;
    logic signed [DATA_W-1:0] val_vec [CAPACITY];

    assign found = |match_vec;

    slst_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .found    (found),
        .head_val (val_vec[0]),
        .ctl      (ctl),
        .count    (count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     lk;
        logic signed [DATA_W-1:0] lv;
        logic                     lo;
        logic signed [DATA_W-1:0] rv;
        logic                     ro;

        if (i == 0)
        begin : g_first
            assign lk = 1'b1;
            assign lv = '0;
            assign lo = 1'b0;
        end
        else
        begin : g_mid
            assign lk = keep_vec[i-1];
            assign lv = val_vec[i-1];
            assign lo = occ_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign rv = '0;
            assign ro = 1'b0;
        end
        else
        begin : g_body
            assign rv = val_vec[i+1];
            assign ro = occ_vec[i+1];
        end

        slst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_keep (lk),
            .left_val  (lv),
            .left_occ  (lo),
            .right_val (rv),
            .right_occ (ro),
            .head_val  (val_vec[0]),
            .keep      (keep_vec[i]),
            .match     (match_vec[i]),
            .val       (val_vec[i]),
            .occ       (occ_vec[i])
        );
    end

`ifndef SYNTH
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count))
        else $error("occupied cells disagree with entry count");

    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + 1'b1) & occ_vec) == '0)
        else $error("occupied cells are not a prefix of the chain");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready && occ_vec[0] && CAPACITY > 1 && occ_vec[CAPACITY > 1 ? 1 : 0]
        |-> val_vec[0] <= val_vec[CAPACITY > 1 ? 1 : 0])
        else $error("head of chain out of order");
`endif

endmodule

`default_nettype wire
